[design/bse_pkg.sv]
`timescale 1ns / 1ps

package bse_pkg;

    localparam int MAX_JOBS     = 16;
    localparam int MAX_MACHINES = 16;
    localparam int TIME_WIDTH   = 24;

    localparam int JOB_W   = $clog2(MAX_JOBS);
    localparam int MACH_W  = $clog2(MAX_MACHINES);
    localparam int JOBC_W  = $clog2(MAX_JOBS + 1);
    localparam int OPN_W   = $clog2(MAX_MACHINES + 1);
    localparam int DUR_W   = 16;
    localparam int CFG_W   = 5;
    localparam int SEL_W   = 2;
    localparam int STAT_W  = 2;
    localparam int FK_W    = 2;

    localparam int RT_DEPTH = MAX_JOBS * MAX_MACHINES;
    localparam int RT_AW    = JOB_W + MACH_W;
    localparam int RT_W     = MACH_W + DUR_W;

    localparam logic [SEL_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [SEL_W-1:0] OP_START = 2'd1;
    localparam logic [SEL_W-1:0] OP_STEP  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_JOB  = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_OP    = 2'd2;
    localparam logic [STAT_W-1:0] ST_BAD_MACH = 2'd3;

    localparam logic [FK_W-1:0] FK_NONE = 2'd0;
    localparam logic [FK_W-1:0] FK_JOB  = 2'd1;
    localparam logic [FK_W-1:0] FK_MACH = 2'd2;

    localparam logic REG_JOBS     = 1'b0;
    localparam logic REG_MACHINES = 1'b1;

    typedef struct packed {
        logic [SEL_W-1:0]  sel;
        logic [JOB_W-1:0]  job;
        logic [OPN_W-1:0]  op;
        logic [STAT_W-1:0] status;
    } item_t;

    typedef struct packed {
        logic [STAT_W-1:0]     status;
        logic [MACH_W-1:0]     op_index;
        logic [TIME_WIDTH-1:0] start_time;
        logic [TIME_WIDTH-1:0] end_time;
        logic [FK_W-1:0]       father_kind;
        logic [JOB_W-1:0]      father_job;
        logic [MACH_W-1:0]     father_op;
        logic [TIME_WIDTH-1:0] makespan;
        logic [JOB_W-1:0]      critical_job;
        logic [MACH_W-1:0]     critical_op;
    } result_t;

    function automatic logic [JOBC_W-1:0] clamp_jobs(input logic [CFG_W-1:0] v);
        logic [JOBC_W-1:0] r;
        if (v == '0)
            r = JOBC_W'(1);
        else if (int'(v) > MAX_JOBS)
            r = JOBC_W'(MAX_JOBS);
        else
            r = JOBC_W'(v);
        return r;
    endfunction

    function automatic logic [OPN_W-1:0] clamp_machines(input logic [CFG_W-1:0] v);
        logic [OPN_W-1:0] r;
        if (v == '0)
            r = OPN_W'(1);
        else if (int'(v) > MAX_MACHINES)
            r = OPN_W'(MAX_MACHINES);
        else
            r = OPN_W'(v);
        return r;
    endfunction

endpackage

[design/bierwirth_schedule_evaluate.sv]
`timescale 1ns / 1ps
// Pipeline: an accepted input beat is registered in the E stage (e_item_reg); when
// it fires, its result is registered in the output register that drives m_tvalid.
// Throughput: one beat per cycle while the output is not stalled; the routing
// RAM is read at accept, the schedule state is read and updated at fire, with forwarding.
// Reset: asynchronous, active low; clears counters, times, makespan and config
// (16 jobs, 16 machines). The routing table is not cleared and must be loaded.

module bierwirth_schedule_evaluate (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // operation[1:0], job[5:2], op_slot[9:6], machine[13:10], duration[29:14], zero pad
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[1:0], op_index[5:2], start_time[29:6], end_time[53:30],
    // father_kind[55:54], father_job[59:56], father_op[63:60],
    // makespan[87:64], critical_job[91:88], critical_op[95:92]
    output logic [95:0] m_tdata
);

    import bse_pkg::*;

    logic [CFG_W-1:0]  jobs_cfg_reg;
    logic [CFG_W-1:0]  mach_cfg_reg;
    logic [JOBC_W-1:0] nj;
    logic [OPN_W-1:0]  nm;

    logic              e_valid_reg;
    item_t             e_item_reg;
    item_t             a_item;
    logic              out_valid_reg;
    result_t           out_result_reg;
    result_t           core_res;

    logic              e_fire;
    logic              s_accept;

    logic [SEL_W-1:0]  in_sel;
    logic [JOB_W-1:0]  in_job;
    logic [MACH_W-1:0] in_slot;
    logic [MACH_W-1:0] in_mach;
    logic [DUR_W-1:0]  in_dur;
    logic [OPN_W-1:0]  a_op;

    logic              ram_we;
    logic              ram_re;
    logic [RT_W-1:0]   ram_rdata;

    assign in_sel  = s_tdata[1:0];
    assign in_job  = s_tdata[5:2];
    assign in_slot = s_tdata[9:6];
    assign in_mach = s_tdata[13:10];
    assign in_dur  = s_tdata[29:14];

    assign nj = clamp_jobs(jobs_cfg_reg);
    assign nm = clamp_machines(mach_cfg_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jobs_cfg_reg <= CFG_W'(MAX_JOBS);
            mach_cfg_reg <= CFG_W'(MAX_MACHINES);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_JOBS:     jobs_cfg_reg <= cfg_data;
                REG_MACHINES: mach_cfg_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    assign e_fire   = e_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !e_valid_reg || e_fire;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        a_item        = '0;
        a_item.sel    = in_sel;
        a_item.job    = in_job;
        a_item.op     = a_op;
        a_item.status = ST_OK;
        case (in_sel)
            OP_LOAD:
            begin
                if (JOBC_W'(in_job) >= nj)
                    a_item.status = ST_BAD_JOB;
                else if (OPN_W'(in_slot) >= nm)
                    a_item.status = ST_NO_OP;
                else if (OPN_W'(in_mach) >= nm)
                    a_item.status = ST_BAD_MACH;
            end
            OP_STEP:
            begin
                if (JOBC_W'(in_job) >= nj)
                    a_item.status = ST_BAD_JOB;
                else if (a_op >= nm)
                    a_item.status = ST_NO_OP;
            end
            default: ;
        endcase
    end

    assign ram_we = s_accept && (in_sel == OP_LOAD) && (a_item.status == ST_OK);
    assign ram_re = s_accept && (in_sel == OP_STEP);

    bse_ram #(
        .WIDTH (RT_W),
        .DEPTH (RT_DEPTH)
    ) u_routing (
        .clk   (clk),
        .we    (ram_we),
        .waddr ({in_job, in_slot}),
        .wdata ({in_mach, in_dur}),
        .re    (ram_re),
        .raddr ({in_job, a_op[MACH_W-1:0]}),
        .rdata (ram_rdata)
    );

    bse_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (e_fire),
        .item        (e_item_reg),
        .rt_machine  (ram_rdata[RT_W-1:DUR_W]),
        .rt_duration (ram_rdata[DUR_W-1:0]),
        .nm          (nm),
        .a_job       (in_job),
        .a_op        (a_op),
        .res         (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_accept)
                e_valid_reg <= 1'b1;
            else if (e_fire)
                e_valid_reg <= 1'b0;
            if (e_fire)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
            e_item_reg <= a_item;
        if (e_fire)
            out_result_reg <= core_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_result_reg.critical_op, out_result_reg.critical_job,
                       out_result_reg.makespan, out_result_reg.father_op,
                       out_result_reg.father_job, out_result_reg.father_kind,
                       out_result_reg.end_time, out_result_reg.start_time,
                       out_result_reg.op_index, out_result_reg.status};

    a_ram_one_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("routing RAM read and written in one cycle");

    a_fire_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        e_fire |=> out_valid_reg)
        else $error("committed beat did not reach the output register");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (e_valid_reg && !e_fire) |=> (e_valid_reg && $stable(e_item_reg)))
        else $error("stalled stage lost its beat");

endmodule

[design/bse_ram.sv]
`timescale 1ns / 1ps

module bse_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/bse_core.sv]
`timescale 1ns / 1ps

module bse_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        fire,
    input  bse_pkg::item_t              item,
    input  logic [bse_pkg::MACH_W-1:0]  rt_machine,
    input  logic [bse_pkg::DUR_W-1:0]   rt_duration,
    input  logic [bse_pkg::OPN_W-1:0]   nm,
    input  logic [bse_pkg::JOB_W-1:0]   a_job,
    output logic [bse_pkg::OPN_W-1:0]   a_op,
    output bse_pkg::result_t            res
);

    import bse_pkg::*;

    logic [OPN_W-1:0]      job_next_op_reg  [MAX_JOBS];
    logic [OPN_W-1:0]      job_next_op_next [MAX_JOBS];
    logic [TIME_WIDTH-1:0] job_end_reg      [MAX_JOBS];
    logic [TIME_WIDTH-1:0] job_end_next     [MAX_JOBS];
    logic [TIME_WIDTH-1:0] mach_end_reg     [MAX_MACHINES];
    logic [TIME_WIDTH-1:0] mach_end_next    [MAX_MACHINES];
    logic [JOB_W-1:0]      mach_job_reg     [MAX_MACHINES];
    logic [JOB_W-1:0]      mach_job_next    [MAX_MACHINES];
    logic [MACH_W-1:0]     mach_op_reg      [MAX_MACHINES];
    logic [MACH_W-1:0]     mach_op_next     [MAX_MACHINES];
    logic [MAX_MACHINES-1:0] mach_used_reg;
    logic [MAX_MACHINES-1:0] mach_used_next;
    logic [TIME_WIDTH-1:0] makespan_reg;
    logic [TIME_WIDTH-1:0] makespan_next;
    logic [JOB_W-1:0]      crit_job_reg;
    logic [JOB_W-1:0]      crit_job_next;
    logic [MACH_W-1:0]     crit_op_reg;
    logic [MACH_W-1:0]     crit_op_next;

    logic                  is_step;
    logic                  step_ok;
    logic [TIME_WIDTH-1:0] job_end;
    logic [TIME_WIDTH-1:0] start_t;
    logic [FK_W-1:0]       fk;
    logic [JOB_W-1:0]      fj;
    logic [MACH_W-1:0]     fo;
    logic [TIME_WIDTH:0]   sum;
    logic [TIME_WIDTH-1:0] end_t;
    logic                  raise;

    assign is_step = (item.sel == OP_STEP);
    assign step_ok = is_step && (item.status == ST_OK) && (OPN_W'(rt_machine) < nm);
    assign job_end = job_end_reg[item.job];

    always_comb
    begin
        start_t = '0;
        fk      = FK_NONE;
        fj      = '0;
        fo      = '0;
        if ((item.op != '0) && (job_end > start_t))
        begin
            start_t = job_end;
            fk      = FK_JOB;
            fj      = item.job;
            fo      = MACH_W'(item.op - OPN_W'(1));
        end
        if (mach_used_reg[rt_machine] && (mach_end_reg[rt_machine] > start_t))
        begin
            start_t = mach_end_reg[rt_machine];
            fk      = FK_MACH;
            fj      = mach_job_reg[rt_machine];
            fo      = mach_op_reg[rt_machine];
        end
    end

    assign sum   = {1'b0, start_t} + (TIME_WIDTH + 1)'(rt_duration);
    assign end_t = sum[TIME_WIDTH] ? {TIME_WIDTH{1'b1}} : sum[TIME_WIDTH-1:0];
    assign raise = end_t > makespan_reg;

    always_comb
    begin
        job_next_op_next = job_next_op_reg;
        job_end_next     = job_end_reg;
        mach_end_next    = mach_end_reg;
        mach_job_next    = mach_job_reg;
        mach_op_next     = mach_op_reg;
        mach_used_next   = mach_used_reg;
        makespan_next    = makespan_reg;
        crit_job_next    = crit_job_reg;
        crit_op_next     = crit_op_reg;
        if (fire && (item.sel == OP_START))
        begin
            for (int i = 0; i < MAX_JOBS; i++)
            begin
                job_next_op_next[i] = '0;
                job_end_next[i]     = '0;
            end
            for (int i = 0; i < MAX_MACHINES; i++)
            begin
                mach_end_next[i] = '0;
                mach_job_next[i] = '0;
                mach_op_next[i]  = '0;
            end
            mach_used_next = '0;
            makespan_next  = '0;
            crit_job_next  = '0;
            crit_op_next   = '0;
        end
        else if (fire && step_ok)
        begin
            job_next_op_next[item.job] = item.op + OPN_W'(1);
            job_end_next[item.job]     = end_t;
            mach_end_next[rt_machine]  = end_t;
            mach_job_next[rt_machine]  = item.job;
            mach_op_next[rt_machine]   = MACH_W'(item.op);
            mach_used_next[rt_machine] = 1'b1;
            if (raise)
            begin
                makespan_next = end_t;
                crit_job_next = item.job;
                crit_op_next  = MACH_W'(item.op);
            end
        end
    end

    // the forwarded view of the next operation, as seen after this beat commits
    assign a_op = job_next_op_next[a_job];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_JOBS; i++)
            begin
                job_next_op_reg[i] <= '0;
                job_end_reg[i]     <= '0;
            end
            for (int i = 0; i < MAX_MACHINES; i++)
            begin
                mach_end_reg[i] <= '0;
                mach_job_reg[i] <= '0;
                mach_op_reg[i]  <= '0;
            end
            mach_used_reg <= '0;
            makespan_reg  <= '0;
            crit_job_reg  <= '0;
            crit_op_reg   <= '0;
        end
        else
        begin
            job_next_op_reg <= job_next_op_next;
            job_end_reg     <= job_end_next;
            mach_end_reg    <= mach_end_next;
            mach_job_reg    <= mach_job_next;
            mach_op_reg     <= mach_op_next;
            mach_used_reg   <= mach_used_next;
            makespan_reg    <= makespan_next;
            crit_job_reg    <= crit_job_next;
            crit_op_reg     <= crit_op_next;
        end
    end

    always_comb
    begin
        res              = '0;
        res.status       = item.status;
        res.makespan     = makespan_next;
        res.critical_job = crit_job_next;
        res.critical_op  = crit_op_next;
        if (is_step)
        begin
            if (item.status != ST_BAD_JOB)
            begin
                res.op_index = MACH_W'(item.op);
            end
            if (item.status == ST_OK)
            begin
                if (step_ok)
                begin
                    res.start_time  = start_t;
                    res.end_time    = end_t;
                    res.father_kind = fk;
                    res.father_job  = fj;
                    res.father_op   = fo;
                end
                else
                begin
                    res.status = ST_BAD_MACH;
                end
            end
        end
    end

    a_no_father_zero_start: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && step_ok && (fk == FK_NONE)) |-> (start_t == '0))
        else $error("start without a father arc is not zero");

    a_end_not_before_start: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && step_ok) |-> (end_t >= start_t))
        else $error("end time earlier than start time");

    a_makespan_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (item.sel != OP_START)) |=> (makespan_reg >= $past(makespan_reg)))
        else $error("makespan fell without a start beat");

endmodule
